FILE: rtl/running_energy_histogram_noise_gate_top_assert.svh
// assertion macros for the noise gate top level
`ifndef RUNNING_ENERGY_HISTOGRAM_NOISE_GATE_TOP_ASSERT_SVH
`define RUNNING_ENERGY_HISTOGRAM_NOISE_GATE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define REH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define REH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define REH_ASSERT_IMP(label, clk, rst, ante, cons)
`define REH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/rehng_pkg.sv
// types and constants shared by the noise gate modules
package rehng_pkg;
   typedef struct packed {
      logic        command;
      logic signed [15:0] energy_sample;
   } req_payload_type;

   typedef struct packed {
      logic        keep_frame;
      logic signed [15:0] noise_estimate;
      logic [9:0]  peak_bin;
      logic [15:0] discarded_total;
   } rsp_payload_type;

   localparam logic CMD_ADD     = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam logic [1:0] REG_ENERGY_MIN   = 2'd0;
   localparam logic [1:0] REG_ENERGY_RANGE = 2'd1;
   localparam logic [1:0] REG_QUIET_LIMIT  = 2'd2;

   localparam logic signed [15:0] NOISE_RESET    = -16'sd25600;
   localparam logic signed [15:0] SEEN_MIN_RESET = 16'sd25600;
   localparam logic signed [15:0] SEEN_MAX_RESET = -16'sd25600;
   localparam logic signed [15:0] EMIN_RESET     = -16'sd5120;
   localparam logic [14:0]        ERANGE_RESET   = 15'd10240;
   localparam logic [7:0]         QLIMIT_RESET   = 8'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_DIV,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_MAX_SCAN,
      ST_HYST,
      ST_PEAK_SCAN,
      ST_HALVE,
      ST_LEVEL_DIV,
      ST_LEVEL,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic add_start;
      logic add_read;
      logic add_write;
      logic max_start;
      logic max_step;
      logic hyst_start;
      logic peak_step;
      logic halve_step;
      logic level_start;
      logic level_finish;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic scan_done;
      logic peak_stop;
   } status_type;
endpackage

FILE: rtl/rehng_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module rehng_divider import rehng_pkg::*; #(
   parameter int NUM_WIDTH = 28,
   parameter int DEN_WIDTH = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0] denominator,
   output logic [NUM_WIDTH-1:0] quotient,
   output logic                 done
);
   localparam int CW = $clog2(NUM_WIDTH + 1);
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH:0]   rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DEN_WIDTH+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[NUM_WIDTH-1]} - {2'b00, den_ff};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CW'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_WIDTH+1]) begin
            rem_in = trial[DEN_WIDTH:0];
            quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DEN_WIDTH-1:0], quo_ff[NUM_WIDTH-1]};
            quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = !busy_ff && !start;
endmodule

FILE: rtl/rehng_datapath.sv
// histogram memory, scalar state and arithmetic of the noise gate
module rehng_datapath import rehng_pkg::*; #(
   parameter int BIN_SCALE   = 1000,
   parameter int BIN_COUNT   = 1001,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  req_payload_type     req,
   input  logic signed [15:0]  energy_min,
   input  logic [14:0]         energy_range,
   input  logic [7:0]          quiet_run_limit,
   output rsp_payload_type     rsp
);
   localparam int AW = $clog2(BIN_COUNT);
   localparam int SW = $clog2(BIN_SCALE + 1);
   localparam int NW = 17 + SW;
   localparam int LW = AW + 15;
   localparam int LS = LW + SW;
   localparam int LPW = 2 * LW + 2;
   localparam int SUMW = LW + 2;
   localparam int HS = COUNT_WIDTH + 3;
   localparam int HPW = 2 * COUNT_WIDTH + 4;
   localparam logic [63:0] LEVEL_MUL =
      ((64'd1 << LS) + 64'(BIN_SCALE) - 64'd1) / 64'(BIN_SCALE);
   localparam logic [63:0] HYST_MUL = ((64'd1 << HS) + 64'd4) / 64'd5;
   localparam logic [32:0] TENTH_MUL = 33'd104858;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0] top_ff, top_in, best_ff, best_in, hyst_ff, hyst_in;
   logic [AW-1:0]          at_ff, at_in;
   logic                   rd_valid_ff;
   logic [AW-1:0]          rd_addr_ff;
   logic signed [15:0]     noise_ff, noise_in, smin_ff, smin_in, smax_ff, smax_in;
   logic [7:0]             quiet_ff, quiet_in;
   logic [15:0]            disc_ff, disc_in;
   logic [AW-1:0]          peak_ff, peak_in;
   logic                   keep_ff, keep_in;
   logic [15:0]            rep_ff, rep_in;
   logic signed [16:0]     span_ff, span_in;
   logic signed [16:0]     e_ext, lo, hi, c;
   logic [16:0]            off;
   logic                   div_start, div_done;
   logic [NW-1:0]          div_num, div_q;
   logic [14:0]            div_den;
   logic [LW-1:0]          prod_ff, lq_ff;
   logic [LPW-1:0]         lq_prod;
   logic [HPW-1:0]         hyst_prod;
   logic [15:0]            span_mag;
   logic [32:0]            tenth_prod;
   logic [12:0]            tenth_mag_ff;
   logic signed [SUMW-1:0] lvl_sum;
   logic signed [16:0]     tenth, twentieth;
   logic                   wr_en;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic                   clear_last;

   assign e_ext = 17'(req.energy_sample);
   assign lo    = 17'(energy_min);
   assign hi    = lo + $signed({2'b00, energy_range});
   always_comb begin
      c = (e_ext < lo) ? lo : e_ext;
      c = (c > hi) ? hi : c;
   end
   assign off       = 17'(c - lo);
   assign div_start = cmd.add_start;
   assign div_num   = NW'(NW'(off) * NW'(BIN_SCALE));
   assign div_den   = energy_range;

   rehng_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(15)) u_div (
      .clock, .reset, .start(div_start), .numerator(div_num),
      .denominator(div_den), .quotient(div_q), .done(div_done)
   );

   // constant divisions by reciprocal multiplication
   assign lq_prod    = LPW'(prod_ff) * LPW'(LEVEL_MUL);
   assign hyst_prod  = HPW'(top_ff) * HPW'(HYST_MUL);
   assign span_mag   = 16'(span_ff[16] ? -span_ff : span_ff);
   assign tenth_prod = 33'(span_mag) * TENTH_MUL;
   assign tenth      = span_ff[16] ? -$signed({4'b0000, tenth_mag_ff})
                                   : $signed({4'b0000, tenth_mag_ff});
   assign twentieth  = span_ff[16] ? -$signed({5'b00000, tenth_mag_ff[12:1]})
                                   : $signed({5'b00000, tenth_mag_ff[12:1]});
   assign lvl_sum    = SUMW'(lq_ff) + SUMW'(energy_min) + SUMW'(twentieth);
   assign clear_last = (addr_ff == AW'(BIN_COUNT - 1));

   always_comb begin
      addr_in = addr_ff; idx_in = idx_ff; top_in = top_ff; best_in = best_ff;
      hyst_in = hyst_ff; at_in = at_ff; noise_in = noise_ff; smin_in = smin_ff;
      smax_in = smax_ff; quiet_in = quiet_ff; disc_in = disc_ff; peak_in = peak_ff;
      keep_in = keep_ff; rep_in = rep_ff; span_in = span_ff;
      wr_en = 1'b0; wr_addr = addr_ff; wr_data = '0; rd_addr = addr_ff;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
         addr_in = clear_last ? '0 : addr_ff + 1'b1;
      end
      if (cmd.add_start) begin
         if (req.energy_sample < noise_ff) begin
            if (quiet_ff != 8'hff) quiet_in = quiet_ff + 1'b1;
         end else begin
            quiet_in = '0;
         end
         if (req.energy_sample < smin_ff) smin_in = req.energy_sample;
         if (req.energy_sample > smax_ff) smax_in = req.energy_sample;
      end
      if (cmd.add_read) begin
         if (energy_range == '0 || div_q >= NW'(BIN_COUNT - 1)) begin
            idx_in = (energy_range == '0) ? '0 : AW'(BIN_COUNT - 1);
         end else begin
            idx_in = AW'(div_q);
         end
         rd_addr = idx_in;
         keep_in = 1'b1;
         if (quiet_ff >= quiet_run_limit) begin
            keep_in = 1'b0;
            if (disc_ff != 16'hffff) disc_in = disc_ff + 1'b1;
         end
      end
      if (cmd.add_write) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = (rd_ff != CMAX) ? rd_ff + 1'b1 : rd_ff;
         rep_in  = disc_ff;
      end
      if (cmd.max_start) begin
         addr_in = '0; top_in = '0;
      end
      if (cmd.max_step) begin
         rd_addr = addr_ff;
         if (!clear_last) addr_in = addr_ff + 1'b1;
         if (rd_valid_ff && rd_ff > top_ff) top_in = rd_ff;
      end
      if (cmd.hyst_start) begin
         hyst_in = COUNT_WIDTH'(hyst_prod >> HS);
         addr_in = '0; best_in = '0; at_in = '0;
      end
      if (cmd.peak_step) begin
         rd_addr = addr_ff;
         if (!clear_last) addr_in = addr_ff + 1'b1;
         if (rd_valid_ff && rd_ff > best_ff) begin
            best_in = rd_ff; at_in = rd_addr_ff;
         end
      end
      if (cmd.halve_step) begin
         rd_addr = addr_ff;
         if (!clear_last) addr_in = addr_ff + 1'b1;
         if (rd_valid_ff) begin
            wr_en = 1'b1; wr_addr = rd_addr_ff; wr_data = rd_ff >> 1;
         end
      end
      if (cmd.level_start) begin
         span_in = 17'(smax_ff) - 17'(smin_ff);
      end
      if (cmd.level_finish) begin
         peak_in = peak_ff;
         smin_in = 16'(17'(smin_ff) + tenth);
         smax_in = 16'(17'(smax_ff) - tenth);
         quiet_in = '0;
         if (lvl_sum > SUMW'(32767)) noise_in = 16'sh7fff;
         else if (lvl_sum < SUMW'(-32768)) noise_in = 16'sh8000;
         else noise_in = 16'(lvl_sum);
         rep_in  = disc_ff;
         disc_in = '0;
         keep_in = 1'b1;
      end
      if (cmd.hyst_start) begin
         addr_in = '0;
      end
      if (cmd.level_start) begin
         peak_in = at_ff;
         addr_in = '0;
      end
   end

   // peak stop: bin plus hysteresis below best so far
   logic [COUNT_WIDTH:0] b_h;
   logic [COUNT_WIDTH-1:0] best_now;
   assign best_now = (rd_ff > best_ff) ? rd_ff : best_ff;
   assign b_h = {1'b0, rd_ff} + {1'b0, hyst_ff};

   assign status.clear_done = clear_last;
   assign status.div_done   = div_done;
   assign status.scan_done  = rd_valid_ff && (rd_addr_ff == AW'(BIN_COUNT - 1));
   assign status.peak_stop  = rd_valid_ff && (b_h < {1'b0, best_now});

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0; rd_valid_ff <= 1'b0;
         noise_ff <= NOISE_RESET; smin_ff <= SEEN_MIN_RESET; smax_ff <= SEEN_MAX_RESET;
         quiet_ff <= '0; disc_ff <= '0; peak_ff <= '0;
      end else begin
         addr_ff <= addr_in;
         rd_valid_ff <= (cmd.max_step || cmd.peak_step || cmd.halve_step) && !cmd.hyst_start;
         noise_ff <= noise_in; smin_ff <= smin_in; smax_ff <= smax_in;
         quiet_ff <= quiet_in; disc_ff <= disc_in; peak_ff <= peak_in;
      end
      idx_ff <= idx_in; top_ff <= top_in; best_ff <= best_in; hyst_ff <= hyst_in;
      at_ff <= at_in; keep_ff <= keep_in; rep_ff <= rep_in; span_ff <= span_in;
      // level terms settle during the halving pass
      prod_ff <= LW'(peak_ff) * LW'(energy_range);
      lq_ff <= LW'(lq_prod >> LS);
      tenth_mag_ff <= 13'(tenth_prod >> 20);
   end

   assign rsp.keep_frame      = keep_ff;
   assign rsp.noise_estimate  = noise_ff;
   assign rsp.peak_bin        = 10'(peak_ff);
   assign rsp.discarded_total = rep_ff;
endmodule

FILE: rtl/rehng_control.sv
// sequencer for the noise gate
module rehng_control import rehng_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       command,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE: if (accept) begin
            state_in = (command == CMD_ADD) ? ST_ADD_DIV : ST_MAX_SCAN;
         end
         ST_ADD_DIV:   if (status.div_done) state_in = ST_ADD_READ;
         ST_ADD_READ:  state_in = ST_ADD_WRITE;
         ST_ADD_WRITE: state_in = ST_RESPOND;
         ST_MAX_SCAN:  if (status.scan_done) state_in = ST_HYST;
         ST_HYST:      state_in = ST_PEAK_SCAN;
         ST_PEAK_SCAN: if (status.peak_stop || status.scan_done) state_in = ST_LEVEL_DIV;
         ST_LEVEL_DIV: state_in = ST_HALVE;
         ST_HALVE:     if (status.scan_done) state_in = ST_LEVEL;
         ST_LEVEL:     state_in = ST_RESPOND;
         ST_RESPOND:   state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:     cmd.clear_step = 1'b1;
         ST_IDLE: begin
            cmd.add_start = accept && (command == CMD_ADD);
            cmd.max_start = accept && (command == CMD_COMPUTE);
         end
         ST_ADD_DIV:   cmd.add_read = status.div_done;
         ST_ADD_READ:  cmd.add_write = 1'b1;
         ST_MAX_SCAN:  cmd.max_step = 1'b1;
         ST_HYST:      cmd.hyst_start = 1'b1;
         ST_PEAK_SCAN: cmd.peak_step = !status.peak_stop;
         ST_LEVEL_DIV: cmd.level_start = 1'b1;
         ST_HALVE:     cmd.halve_step = 1'b1;
         ST_LEVEL:     cmd.level_finish = 1'b1;
         ST_RESPOND:   cmd.rsp_load = 1'b1;
         default:      cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_RESPOND) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: rtl/running_energy_histogram_noise_gate_top.sv
// top level of the running energy histogram noise gate
// usage:
// - req channel carries one transaction per frame: command 0 adds an energy
//   sample, command 1 computes the noise level
// - rsp channel returns one transaction per request: keep flag, noise level,
//   peak bin and discard total
// - csr port is apb-style, writes energy_min (0x0), energy_range (0x4) and
//   quiet_run_limit (0x8), pready always high
// - an add raises rsp_valid after 27 steps of the bit-serial bin divider,
//   then a histogram read, write and response load
// - a compute raises rsp_valid after a max pass, a peak pass (shorter when
//   it stops early) and a halving pass over the histogram memory, which
//   has one read port and one write port
// - the next request is taken in the cycle after the rsp transaction, so a
//   new add is not taken before the previous one has been answered
// - after reset a clearing pass over all BIN_COUNT bins zeroes the histogram,
//   req_ready stays low during it
// - one transaction is in flight at a time; a stalled rsp holds the result
//   and req_ready stays low until it is taken
`include "running_energy_histogram_noise_gate_top_assert.svh"
module running_energy_histogram_noise_gate_top import rehng_pkg::*; #(
   parameter int BIN_SCALE   = 1000,
   parameter int BIN_COUNT   = 1001,
   parameter int COUNT_WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);
   logic signed [15:0] emin_ff;
   logic [14:0]        erange_ff;
   logic [7:0]         qlimit_ff;
   cmd_type            cmd;
   status_type         status;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         emin_ff <= EMIN_RESET; erange_ff <= ERANGE_RESET; qlimit_ff <= QLIMIT_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_ENERGY_MIN:   emin_ff   <= pwdata[15:0];
            REG_ENERGY_RANGE: erange_ff <= pwdata[14:0];
            REG_QUIET_LIMIT:  qlimit_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ENERGY_MIN:   prdata = {{16{emin_ff[15]}}, emin_ff};
         REG_ENERGY_RANGE: prdata = {17'd0, erange_ff};
         REG_QUIET_LIMIT:  prdata = {24'd0, qlimit_ff};
         default:          prdata = '0;
      endcase
   end

   rehng_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .command(req_payload.command),
      .rsp_valid, .rsp_ready, .status, .cmd
   );

   rehng_datapath #(.BIN_SCALE(BIN_SCALE), .BIN_COUNT(BIN_COUNT),
      .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock, .reset, .cmd, .status, .req(req_payload), .energy_min(emin_ff),
      .energy_range(erange_ff), .quiet_run_limit(qlimit_ff), .rsp(rsp_payload)
   );

   `REH_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `REH_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `REH_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready)
   `REH_ASSERT_IMP(a_ctrl_onehot, clock, reset, 1'b1, $onehot0({cmd.add_start, cmd.max_start, cmd.clear_step}))
endmodule
